>>> src/olist_pkg.sv
// ----------------------------------------------------------------------------
// olist_pkg
// Shared widths, request codes and control types for the ordered list engine.
// ----------------------------------------------------------------------------
package olist_pkg;

  localparam int CAPACITY = 16;

  localparam int DATA_W = 32;
  localparam int REQ_W  = 3;
  localparam int POS_W  = 5;
  localparam int FIDX_W = 5;

  // count holds 0..CAPACITY, a cell index 0..CAPACITY-1
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam logic signed [FIDX_W-1:0] FOUND_NONE = '1;

  typedef enum logic [REQ_W-1:0] {
    REQ_APPEND = 3'd0,
    REQ_INSERT = 3'd1,
    REQ_REMOVE = 3'd2,
    REQ_FIND   = 3'd3,
    REQ_DUMP   = 3'd4
  } req_t;

  typedef enum logic [2:0] {
    CH_HOLD,
    CH_APPEND,
    CH_INSERT,
    CH_REMOVE,
    CH_ROTATE
  } chain_op_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_LEFT,
    CELL_RIGHT
  } cell_cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_DUMP
  } state_t;

  typedef struct packed {
    chain_op_t                 op;
    logic [POS_W-1:0]          pos;
    logic [CNT_W-1:0]          count;
    logic signed [DATA_W-1:0]  value;
  } chain_ctrl_t;

endpackage

>>> src/olist_if.sv
// ----------------------------------------------------------------------------
// olist_if
// Request and response channels of the ordered list engine.
// ----------------------------------------------------------------------------
interface olist_req_if import olist_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [REQ_W-1:0]         req_type;
  logic [POS_W-1:0]         position;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, req_type, position, value, input ready);
  modport sink   (input valid, req_type, position, value, output ready);
endinterface

interface olist_rsp_if import olist_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     status;
  logic signed [FIDX_W-1:0] found_index;
  logic signed [DATA_W-1:0] entry_value;
  logic                     last;

  modport source (output valid, status, found_index, entry_value, last, input ready);
  modport sink   (input valid, status, found_index, entry_value, last, output ready);
endinterface

>>> src/olist_cell.sv
// ----------------------------------------------------------------------------
// olist_cell
// One list slot: holds an entry, loads, shifts from a neighbor, compares.
// ----------------------------------------------------------------------------
module olist_cell import olist_pkg::*; (
  input  logic                     clk,
  input  cell_cmd_t                cmd,
  input  logic signed [DATA_W-1:0] load_data,
  input  logic signed [DATA_W-1:0] left_data,
  input  logic signed [DATA_W-1:0] right_data,
  input  logic signed [DATA_W-1:0] key,
  output logic signed [DATA_W-1:0] data,
  output logic                     match
);

  always_ff @(posedge clk) begin
    unique case (cmd)
      CELL_LOAD:  data <= load_data;
      CELL_LEFT:  data <= left_data;
      CELL_RIGHT: data <= right_data;
      default:    data <= data;
    endcase
  end

  assign match = (data == key);

endmodule

>>> src/olist_chain.sv
// ----------------------------------------------------------------------------
// olist_chain
// Row of list cells with per-cell command decode and first-match encoder.
// ----------------------------------------------------------------------------
module olist_chain import olist_pkg::*; (
  input  logic                     clk,
  input  chain_ctrl_t              ctrl,
  output logic signed [DATA_W-1:0] head,
  output logic                     found,
  output logic [IDX_W-1:0]         found_pos
);

  logic signed [DATA_W-1:0] cell_data [CAPACITY];
  logic [CAPACITY-1:0]      hit;
  logic [CMP_W-1:0]         cnt;
  logic [CMP_W-1:0]         pos;
  logic signed [DATA_W-1:0] load_data;

  assign cnt  = CMP_W'(ctrl.count);
  assign pos  = CMP_W'(ctrl.pos);
  assign head = cell_data[0];

  // dump rotates the head back in at the tail
  assign load_data = (ctrl.op == CH_ROTATE) ? cell_data[0] : ctrl.value;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [CMP_W-1:0] ME   = CMP_W'(i);
    localparam logic [CMP_W-1:0] NEXT = CMP_W'(i + 1);

    cell_cmd_t                cmd;
    logic signed [DATA_W-1:0] left_data;
    logic signed [DATA_W-1:0] right_data;
    logic                     match;

    assign left_data  = (i == 0) ? cell_data[i] : cell_data[(i == 0) ? 0 : i - 1];
    assign right_data = (i == CAPACITY - 1) ? cell_data[i]
                      : cell_data[(i == CAPACITY - 1) ? i : i + 1];

    always_comb begin
      cmd = CELL_HOLD;
      unique case (ctrl.op)
        CH_APPEND: begin
          if (ME == cnt) cmd = CELL_LOAD;
        end
        CH_INSERT: begin
          if (ME == pos) cmd = CELL_LOAD;
          else if (ME > pos && ME <= cnt) cmd = CELL_LEFT;
        end
        CH_REMOVE: begin
          if (ME >= pos && NEXT < cnt) cmd = CELL_RIGHT;
        end
        CH_ROTATE: begin
          if (NEXT < cnt) cmd = CELL_RIGHT;
          else if (NEXT == cnt) cmd = CELL_LOAD;
        end
        default: cmd = CELL_HOLD;
      endcase
    end

    olist_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .load_data  (load_data),
      .left_data  (left_data),
      .right_data (right_data),
      .key        (ctrl.value),
      .data       (cell_data[i]),
      .match      (match)
    );

    assign hit[i] = match && (ME < cnt);
  end

  // lowest matching slot wins
  always_comb begin
    found     = 1'b0;
    found_pos = '0;
    for (int k = CAPACITY - 1; k >= 0; k--) begin
      if (hit[k]) begin
        found     = 1'b1;
        found_pos = IDX_W'(k);
      end
    end
  end

endmodule

>>> src/ordered_list_engine.sv
// ----------------------------------------------------------------------------
// ordered_list_engine
// Ordered list of signed 32-bit values kept in a shifting chain of cells.
//
//   channel | dir | fields
//   req     | in  | req_type, position, value
//   rsp     | out | status, found_index, entry_value, last
//
// Append, insert, remove and find: the cell row shifts or compares all slots
// in the accepting cycle, and the result sits in an output register. A dump
// gives the stored entries in order, one per response, rotating the row once;
// an empty dump gives nothing.
// Reset clears the state, the count and the output valid flag; entries and output fields are undefined.
// req.ready drops during a dump and while the output register is held.
// ----------------------------------------------------------------------------
module ordered_list_engine import olist_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  olist_req_if.sink  req,
  olist_rsp_if.source rsp
);

  state_t            state, state_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [IDX_W-1:0]  dump_idx, dump_idx_next;

  logic                     out_valid;
  logic                     out_status;
  logic signed [FIDX_W-1:0] out_found;
  logic signed [DATA_W-1:0] out_entry;
  logic                     out_last;

  logic                     out_load;
  logic                     status_next;
  logic signed [FIDX_W-1:0] found_next;
  logic signed [DATA_W-1:0] entry_next;
  logic                     last_next;

  chain_ctrl_t              ctrl;
  logic signed [DATA_W-1:0] head;
  logic                     found;
  logic [IDX_W-1:0]         found_pos;

  logic             out_free;
  logic             req_fire;
  logic             full;
  logic             dump_last;
  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] cnt_ext;

  assign out_free  = !out_valid || rsp.ready;
  assign req.ready = (state == ST_IDLE) && out_free;
  assign req_fire  = req.valid && req.ready;
  assign full      = (count == CNT_W'(CAPACITY));
  assign pos_ext   = CMP_W'(req.position);
  assign cnt_ext   = CMP_W'(count);
  assign dump_last = (CNT_W'(dump_idx) + CNT_W'(1) == count);

  olist_chain u_chain (
    .clk       (clk),
    .ctrl      (ctrl),
    .head      (head),
    .found     (found),
    .found_pos (found_pos)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_fire && req.req_type == REQ_DUMP && count != '0) state_next = ST_DUMP;
      end
      ST_DUMP: begin
        if (out_free && dump_last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs: chain control, count update, result
  always_comb begin
    ctrl.op       = CH_HOLD;
    ctrl.pos      = req.position;
    ctrl.count    = count;
    ctrl.value    = req.value;
    count_next    = count;
    dump_idx_next = dump_idx;
    out_load      = 1'b0;
    status_next   = 1'b0;
    found_next    = '0;
    entry_next    = '0;
    last_next     = 1'b1;
    unique case (state)
      ST_IDLE: begin
        if (req_fire) begin
          unique case (req_t'(req.req_type))
            REQ_APPEND: begin
              out_load = 1'b1;
              if (!full) begin
                ctrl.op    = CH_APPEND;
                count_next = count + CNT_W'(1);
              end else begin
                status_next = 1'b1;
              end
            end
            REQ_INSERT: begin
              out_load = 1'b1;
              if (!full && pos_ext <= cnt_ext) begin
                ctrl.op    = CH_INSERT;
                count_next = count + CNT_W'(1);
              end else begin
                status_next = 1'b1;
              end
            end
            REQ_REMOVE: begin
              out_load = 1'b1;
              if (pos_ext < cnt_ext) begin
                ctrl.op    = CH_REMOVE;
                count_next = count - CNT_W'(1);
              end else begin
                status_next = 1'b1;
              end
            end
            REQ_FIND: begin
              out_load   = 1'b1;
              found_next = found ? FIDX_W'(found_pos) : FOUND_NONE;
            end
            REQ_DUMP: begin
              dump_idx_next = '0;
            end
            default: begin
              out_load    = 1'b1;
              status_next = 1'b1;
            end
          endcase
        end
      end
      ST_DUMP: begin
        if (out_free) begin
          out_load      = 1'b1;
          entry_next    = head;
          last_next     = dump_last;
          ctrl.op       = CH_ROTATE;
          dump_idx_next = dump_idx + IDX_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      dump_idx  <= '0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      dump_idx <= dump_idx_next;
      if (out_load) out_valid <= 1'b1;
      else if (rsp.ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status <= status_next;
      out_found  <= found_next;
      out_entry  <= entry_next;
      out_last   <= last_next;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.found_index = out_found;
  assign rsp.entry_value = out_entry;
  assign rsp.last        = out_last;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("list count above capacity");

  a_dump_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == ST_DUMP |-> count != '0)
    else $error("dump running on empty list");

  a_single_result: assert property (@(posedge clk) disable iff (rst)
    req_fire && req.req_type != REQ_DUMP |=> rsp.valid && rsp.last)
    else $error("accepted request produced no result");

  a_append_grows: assert property (@(posedge clk) disable iff (rst)
    req_fire && req.req_type == REQ_APPEND && !full |=> count == $past(count) + CNT_W'(1))
    else $error("append did not grow the list");

  a_dump_keeps_count: assert property (@(posedge clk) disable iff (rst)
    state == ST_DUMP |=> $stable(count))
    else $error("count changed during dump");
`endif

endmodule
